[hw/rtl/cal_pkg.sv]
// Shared types, sizes and codes of the compacting array list.
`default_nettype none

package cal_pkg;

    // Store geometry
    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths
    localparam int KIND_W = 2;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;
    localparam int POS_W  = 6;

    // Stream word widths, padded to whole bytes
    localparam int IN_DATA_W  = ((VAL_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VAL_W + POS_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_DUMP   = 2'd2,
        REQ_NONE   = 2'd3
    } req_kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_ENTRY     = 3'd4
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT,
        S_SHIFT_WR,
        S_DUMP_RD,
        S_DUMP_OUT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic  load_in;
        logic  idx_inc;
        logic  rd_cur;
        logic  rd_nxt;
        logic  wr_append;
        logic  wr_shift;
        logic  cnt_inc;
        logic  cnt_dec;
        logic  emit;
        stat_t emit_status;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        req_kind_t kind;
        logic      full;
        logic      empty;
        logic      idx_end;
        logic      nxt_end;
        logic      hit;
        logic      out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/cal_dp.sv]
// Datapath of the compacting array list: entry memory, count, index and output word.
`default_nettype none

module cal_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cal_pkg::dp_cmd_t              cmd,
    output cal_pkg::dp_stat_t                  stat,
    input  wire logic [cal_pkg::KIND_W-1:0]    in_kind,
    input  wire logic [cal_pkg::VAL_W-1:0]     in_value,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [cal_pkg::STAT_W-1:0]         out_status,
    output logic [cal_pkg::VAL_W-1:0]          out_entry,
    output logic [cal_pkg::POS_W-1:0]          out_position,
    output logic                               out_last
);
    import cal_pkg::*;

    logic [VAL_W-1:0]  mem [DEPTH];
    logic [VAL_W-1:0]  rdata_reg;
    logic [VAL_W-1:0]  val_reg;
    req_kind_t         kind_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  idx_plus;
    logic [IDX_W-1:0]  raddr;
    logic [IDX_W-1:0]  waddr;
    logic [VAL_W-1:0]  wdata;
    logic              mem_we;
    logic              mem_re;

    logic              ovalid_reg, ovalid_next;
    stat_t             ostat_reg;
    logic [VAL_W-1:0]  oentry_reg;
    logic [POS_W-1:0]  opos_reg;
    logic              olast_reg;
    logic              out_free;
    logic              is_entry;

    assign idx_plus = idx_reg + CNT_W'(1);
    assign out_free = !ovalid_reg || out_ready;

    // Report status to the controller
    always_comb
    begin
        stat.kind     = kind_reg;
        stat.full     = (cnt_reg >= CNT_W'(DEPTH));
        stat.empty    = (cnt_reg == '0);
        stat.idx_end  = (idx_reg >= cnt_reg);
        stat.nxt_end  = (idx_plus >= cnt_reg);
        stat.hit      = (rdata_reg == val_reg);
        stat.out_free = out_free;
    end

    // Latch the request word
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            val_reg  <= in_value;
            kind_reg <= req_kind_t'(in_kind);
        end
    end

    // Count and scan index
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (cmd.cnt_dec)
            cnt_next = cnt_reg - CNT_W'(1);

        idx_next = idx_reg;
        if (cmd.load_in)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_plus;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // Memory ports: append or shift-down write, current or next read
    assign mem_we = cmd.wr_append || cmd.wr_shift;
    assign waddr  = cmd.wr_append ? cnt_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wdata  = cmd.wr_append ? val_reg : rdata_reg;
    assign mem_re = cmd.rd_cur || cmd.rd_nxt;
    assign raddr  = cmd.rd_nxt ? idx_plus[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (mem_re)
            rdata_reg <= mem[raddr];
    end

    // Output word register
    assign is_entry = (cmd.emit_status == STAT_ENTRY);

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.emit)
            ovalid_next = 1'b1;
        else if (out_ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else
            ovalid_reg <= ovalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            ostat_reg  <= cmd.emit_status;
            oentry_reg <= is_entry ? rdata_reg : '0;
            opos_reg   <= is_entry ? POS_W'(idx_reg) : '0;
            olast_reg  <= is_entry ? stat.nxt_end : 1'b1;
        end
    end

    assign out_valid    = ovalid_reg;
    assign out_status   = ostat_reg;
    assign out_entry    = oentry_reg;
    assign out_position = opos_reg;
    assign out_last     = olast_reg;

    // Checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond capacity");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_append |-> (cnt_reg < CNT_W'(DEPTH)) && cmd.cnt_inc)
        else $error("append without room or without count update");

    a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> cnt_reg != '0)
        else $error("count decrement on empty list");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("output word overwritten before taken");

    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_shift |-> idx_plus < cnt_reg)
        else $error("shift write past end of list");

endmodule

`default_nettype wire

[hw/rtl/cal_ctrl.sv]
// Controller state machine of the compacting array list.
`default_nettype none

module cal_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cal_pkg::dp_stat_t stat,
    output cal_pkg::dp_cmd_t       cmd
);
    import cal_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DECODE;
            S_DECODE:
                unique case (stat.kind)
                    REQ_INSERT:
                        if (stat.out_free)
                            state_next = S_IDLE;
                    REQ_DELETE:
                        state_next = S_SRCH_RD;
                    REQ_DUMP:
                        if (!stat.empty)
                            state_next = S_DUMP_RD;
                        else if (stat.out_free)
                            state_next = S_IDLE;
                    REQ_NONE:
                        state_next = S_IDLE;
                endcase
            S_SRCH_RD:
                if (!stat.idx_end)
                    state_next = S_SRCH_CMP;
                else if (stat.out_free)
                    state_next = S_IDLE;
            S_SRCH_CMP:
                state_next = stat.hit ? S_SHIFT : S_SRCH_RD;
            S_SHIFT:
                if (!stat.nxt_end)
                    state_next = S_SHIFT_WR;
                else if (stat.out_free)
                    state_next = S_IDLE;
            S_SHIFT_WR:
                state_next = S_SHIFT;
            S_DUMP_RD:
                state_next = S_DUMP_OUT;
            S_DUMP_OUT:
                if (stat.out_free)
                    state_next = stat.nxt_end ? S_IDLE : S_DUMP_RD;
        endcase
    end

    // Commands
    always_comb
    begin
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.emit_status = STAT_DONE;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_DECODE:
                unique case (stat.kind)
                    REQ_INSERT:
                        if (stat.out_free)
                        begin
                            cmd.emit = 1'b1;
                            if (stat.full)
                                cmd.emit_status = STAT_FULL;
                            else
                            begin
                                cmd.wr_append = 1'b1;
                                cmd.cnt_inc   = 1'b1;
                            end
                        end
                    REQ_DUMP:
                        if (stat.empty && stat.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = STAT_EMPTY;
                        end
                    REQ_DELETE, REQ_NONE:
                        cmd.emit = 1'b0;
                endcase
            S_SRCH_RD:
                if (!stat.idx_end)
                    cmd.rd_cur = 1'b1;
                else if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = STAT_NOT_FOUND;
                end
            S_SRCH_CMP:
                cmd.idx_inc = !stat.hit;
            S_SHIFT:
                if (!stat.nxt_end)
                    cmd.rd_nxt = 1'b1;
                else if (stat.out_free)
                begin
                    cmd.cnt_dec = 1'b1;
                    cmd.emit    = 1'b1;
                end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            S_DUMP_RD:
                cmd.rd_cur = 1'b1;
            S_DUMP_OUT:
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = STAT_ENTRY;
                    cmd.idx_inc     = 1'b1;
                end
        endcase
    end

    // Checks
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> state_reg == S_DECODE)
        else $error("accepted word not decoded");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_append && cmd.wr_shift))
        else $error("two memory writes at once");

    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SRCH_CMP |-> $past(cmd.rd_cur))
        else $error("compare without a fresh read");

endmodule

`default_nettype wire

[hw/rtl/compacting_array_list.sv]
// Top level of the compacting array list: stream ports around controller and datapath.
//
// Holds an ordered list of up to DEPTH (64) signed 32-bit values in a single-port-write,
// single-port-read memory. One request word is taken at a time; s_axis_tready is high
// only while the block is idle. Insert appends the value at the end of the list, or
// reports full, and emits its result word once the output register is free. Delete scans
// the list entry by entry (registered memory read, then compare) up to the first match,
// then moves each later entry down one place (registered read, then write). Dump emits
// one result word per entry and waits while the output word is not taken. Every request
// gives one result word with tlast set, except dump of a non-empty list, which gives one
// word per entry with tlast on the final one, and request kind 3, which gives none. A
// single output register sits between the block and the master side.
`default_nettype none

module compacting_array_list (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [cal_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] value
    input  wire logic [cal_pkg::KIND_W-1:0]     s_axis_tuser,   // [1:0] req_type
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [cal_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // [31:0] entry, [37:32] position
    output logic [cal_pkg::STAT_W-1:0]          m_axis_tuser,   // [2:0] status
    output logic                                m_axis_tlast
);
    import cal_pkg::*;

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [VAL_W-1:0]  out_entry;
    logic [POS_W-1:0]  out_position;

    cal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cal_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_kind      (s_axis_tuser),
        .in_value     (s_axis_tdata[VAL_W-1:0]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_status   (m_axis_tuser),
        .out_entry    (out_entry),
        .out_position (out_position),
        .out_last     (m_axis_tlast)
    );

    // Pack the result word, padding to whole bytes
    assign m_axis_tdata = OUT_DATA_W'({out_position, out_entry});

endmodule

`default_nettype wire
